>>> rtl/vdma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdma_pkg
// Types and codes shared by the VRAM DMA controller modules.
// ----------------------------------------------------------------------------
package vdma_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   localparam logic [2:0] SEL_SRC_HI = 3'd0;
   localparam logic [2:0] SEL_SRC_LO = 3'd1;
   localparam logic [2:0] SEL_DST_HI = 3'd2;
   localparam logic [2:0] SEL_DST_LO = 3'd3;
   localparam logic [2:0] SEL_CTRL   = 3'd4;

   localparam logic [6:0] BLOCKS_IDLE   = 7'h7F;
   localparam logic [7:0] ADDR_LO_MASK  = 8'hF0;
   localparam logic [4:0] DST_HI_MASK   = 5'h1F;
   localparam logic [7:0] UNUSED_READ   = 8'hFF;
   localparam logic [1:0] MODE_HBLANK   = 2'd0;

   typedef struct packed {
      op_type     op;
      logic [2:0] reg_sel;
      logic [7:0] write_data;
      logic [1:0] video_mode;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        transfer_active;
      logic        copy_valid;
      logic [15:0] src_addr;
      logic [12:0] vram_addr;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/vdma_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdma_regs
// Address registers, transfer counters and the per-cycle result logic.
// ----------------------------------------------------------------------------
module vdma_regs
   import vdma_pkg::*;
#(
   parameter int BYTES_PER_TICK = 2,
   parameter int BLOCK_BYTES    = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   output rsp_type      result,
   output logic         done
);

   localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
   localparam int STEP_W = (BYTES_PER_TICK > 1) ? $clog2(BYTES_PER_TICK) : 1;
   localparam logic [CNT_W-1:0]  BLOCK_CNT = CNT_W'(BLOCK_BYTES);
   localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BYTES_PER_TICK - 1);

   logic [15:0]       src_ff, src_in;
   logic [15:0]       dst_ff, dst_in;
   logic              running_ff, running_in;
   logic              hblank_ff, hblank_in;
   logic [6:0]        blocks_ff, blocks_in;
   logic [CNT_W-1:0]  bytes_ff, bytes_in;
   logic              was_hblank_ff, was_hblank_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic in_hblank;
   logic block_end;

   always_comb begin
      src_in        = src_ff;
      dst_in        = dst_ff;
      running_in    = running_ff;
      hblank_in     = hblank_ff;
      blocks_in     = blocks_ff;
      bytes_in      = bytes_ff;
      was_hblank_in = was_hblank_ff;
      step_in       = '0;
      result        = '0;
      result.last   = 1'b1;
      done          = 1'b1;
      block_end     = 1'b0;
      in_hblank     = (item.video_mode == MODE_HBLANK);

      unique case (item.op)
         OP_WRITE: begin
            unique case (item.reg_sel)
               SEL_SRC_HI: src_in[15:8] = item.write_data;
               SEL_SRC_LO: src_in[7:0]  = item.write_data & ADDR_LO_MASK;
               SEL_DST_HI: dst_in[15:8] = {3'b000, item.write_data[4:0] & DST_HI_MASK};
               SEL_DST_LO: dst_in[7:0]  = item.write_data & ADDR_LO_MASK;
               SEL_CTRL: begin
                  if (!running_ff) begin
                     hblank_in  = item.write_data[7];
                     blocks_in  = item.write_data[6:0];
                     bytes_in   = BLOCK_CNT;
                     running_in = 1'b1;
                  end else begin
                     running_in = item.write_data[7];
                  end
               end
               default: ;
            endcase
         end
         OP_READ: begin
            unique case (item.reg_sel)
               SEL_SRC_HI: result.read_data = src_ff[15:8];
               SEL_SRC_LO: result.read_data = src_ff[7:0];
               SEL_DST_HI: result.read_data = dst_ff[15:8];
               SEL_DST_LO: result.read_data = dst_ff[7:0];
               SEL_CTRL:   result.read_data = {~running_ff, blocks_ff};
               default:    result.read_data = UNUSED_READ;
            endcase
         end
         OP_QUERY: begin
            was_hblank_in = in_hblank;
            if (running_ff) begin
               if (!hblank_ff) begin
                  result.transfer_active = 1'b1;
               end else begin
                  result.transfer_active = (!was_hblank_ff && in_hblank) ||
                     (bytes_ff != '0 && bytes_ff < BLOCK_CNT);
               end
            end
         end
         OP_TICK: begin
            if (running_ff) begin
               if (bytes_ff != '0) begin
                  // one copy command per cycle in which fire is high
                  result.copy_valid = 1'b1;
                  result.src_addr   = src_ff;
                  result.vram_addr  = dst_ff[12:0];
                  src_in   = src_ff + 16'd1;
                  dst_in   = dst_ff + 16'd1;
                  bytes_in = bytes_ff - ONE_CNT;
                  if (step_ff == STEP_LAST || bytes_ff == ONE_CNT) begin
                     block_end = (bytes_ff == ONE_CNT);
                  end else begin
                     result.last = 1'b0;
                     done        = 1'b0;
                     step_in     = step_ff + 1'b1;
                  end
               end else begin
                  block_end = 1'b1;
               end
               if (block_end) begin
                  if (blocks_ff != '0) begin
                     blocks_in = blocks_ff - 7'd1;
                     bytes_in  = BLOCK_CNT;
                  end else begin
                     blocks_in  = BLOCKS_IDLE;
                     running_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff        <= '0;
         dst_ff        <= '0;
         running_ff    <= 1'b0;
         hblank_ff     <= 1'b0;
         blocks_ff     <= BLOCKS_IDLE;
         bytes_ff      <= BLOCK_CNT;
         was_hblank_ff <= 1'b0;
         step_ff       <= '0;
      end else if (fire) begin
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         running_ff    <= running_in;
         hblank_ff     <= hblank_in;
         blocks_ff     <= blocks_in;
         bytes_ff      <= bytes_in;
         was_hblank_ff <= was_hblank_in;
         step_ff       <= step_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/vram_dma_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vram_dma_controller
// VRAM DMA unit: general and h-blank transfers issued as byte copy commands.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with a req_type payload: register
// write, register read, transfer tick or activity query. Each request gives
// one or more responses on rsp_valid/rsp_ready; rsp_data.last marks the
// final one of a request.
// A request is taken into an input register; the result logic registers its
// responses in the output register. Writes, reads, queries and idle ticks
// give one response each and sustain one request per cycle while the
// receiver does not stall. A running tick gives one copy command per cycle
// while the receiver keeps up, up to BYTES_PER_TICK (fewer at the end of a
// block). The next request is taken in the cycle the current one finishes.
// When the receiver stalls, the output register holds its response and the
// input register holds the pending request; req_ready drops until room frees.
// Synchronous reset clears both addresses, stops any transfer, sets the
// block count to 0x7F and empties both registers.
// ----------------------------------------------------------------------------
module vram_dma_controller
   import vdma_pkg::*;
#(
   parameter int BYTES_PER_TICK = 2,
   parameter int BLOCK_BYTES    = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    cur_valid_ff;
   req_type cur_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic    fire;
   logic    done;
   rsp_type result;

   assign fire      = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !cur_valid_ff || (fire && done);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   vdma_regs #(
      .BYTES_PER_TICK (BYTES_PER_TICK),
      .BLOCK_BYTES    (BLOCK_BYTES)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (cur_ff),
      .result (result),
      .done   (done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         cur_valid_ff <= 1'b1;
      end else if (fire && done) begin
         cur_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cur_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

endmodule
`default_nettype wire

>>> sim/vram_dma_controller_test.sv
// ----------------------------------------------------------------------------
// vram_dma_controller_test
// Self-checking testbench for the VRAM DMA controller. Directed register and
// transfer sequences come first, then a back-pressure burst, then random
// transfer programs under four idling phases. A predictor written in this
// file builds the expected responses of each accepted transaction, and each
// response is checked field by field in order.
// ----------------------------------------------------------------------------
module vram_dma_controller_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vdma_pkg::*;

   localparam int BYTES_PER_TICK = 2;
   localparam int BLOCK_BYTES    = 16;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int MAX_REPORTS    = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predicted state of the controller
   logic [15:0] src_shadow;
   logic [15:0] dst_shadow;
   logic        dma_running;
   logic        hblank_xfer;
   logic [6:0]  blocks_remaining;
   logic [4:0]  block_bytes_remaining;
   logic        in_hblank_prev;
   rsp_type     responses_due[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_len       = 0;
   int hold_count     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   vram_dma_controller #(
      .BYTES_PER_TICK(BYTES_PER_TICK),
      .BLOCK_BYTES   (BLOCK_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void compute_dma_responses(input req_type item);
      rsp_type r;
      logic    now_hblank;
      int      copies;
      r = '0;
      r.last = 1'b1;
      case (item.op)
         OP_WRITE: begin
            case (item.reg_sel)
               SEL_SRC_HI: src_shadow[15:8] = item.write_data;
               SEL_SRC_LO: src_shadow[7:0] = item.write_data & ADDR_LO_MASK;
               SEL_DST_HI: dst_shadow[15:8] = {3'b000, item.write_data[4:0] & DST_HI_MASK};
               SEL_DST_LO: dst_shadow[7:0] = item.write_data & ADDR_LO_MASK;
               SEL_CTRL: begin
                  if (!dma_running) begin
                     hblank_xfer = item.write_data[7];
                     blocks_remaining = item.write_data[6:0];
                     block_bytes_remaining = 5'(BLOCK_BYTES);
                     dma_running = 1'b1;
                  end else begin
                     // while busy only the run flag is taken, counters stay
                     dma_running = item.write_data[7];
                  end
               end
               default: ;
            endcase
            responses_due.push_back(r);
         end
         OP_READ: begin
            case (item.reg_sel)
               SEL_SRC_HI: r.read_data = src_shadow[15:8];
               SEL_SRC_LO: r.read_data = src_shadow[7:0];
               SEL_DST_HI: r.read_data = dst_shadow[15:8];
               SEL_DST_LO: r.read_data = dst_shadow[7:0];
               SEL_CTRL:   r.read_data = {~dma_running, blocks_remaining};
               default:    r.read_data = UNUSED_READ;
            endcase
            responses_due.push_back(r);
         end
         OP_QUERY: begin
            now_hblank = (item.video_mode == MODE_HBLANK);
            r.transfer_active = dma_running && (!hblank_xfer
               || (!in_hblank_prev && now_hblank)
               || (block_bytes_remaining > 0 && block_bytes_remaining < BLOCK_BYTES));
            in_hblank_prev = now_hblank;
            responses_due.push_back(r);
         end
         default: begin
            if (!dma_running) begin
               responses_due.push_back(r);
            end else begin
               copies = (block_bytes_remaining < BYTES_PER_TICK) ?
                        int'(block_bytes_remaining) : BYTES_PER_TICK;
               for (int i = 0; i < copies; i++) begin
                  r = '0;
                  r.copy_valid = 1'b1;
                  r.src_addr = src_shadow;
                  r.vram_addr = dst_shadow[12:0];
                  r.last = (i == copies - 1);
                  responses_due.push_back(r);
                  src_shadow = src_shadow + 16'd1;
                  dst_shadow = dst_shadow + 16'd1;
                  block_bytes_remaining = block_bytes_remaining - 5'd1;
               end
               if (block_bytes_remaining == 0) begin
                  if (blocks_remaining != 0) begin
                     blocks_remaining = blocks_remaining - 7'd1;
                     block_bytes_remaining = 5'(BLOCK_BYTES);
                  end else begin
                     blocks_remaining = BLOCKS_IDLE;
                     dma_running = 1'b0;
                  end
               end
               if (copies == 0) begin
                  r = '0;
                  r.last = 1'b1;
                  responses_due.push_back(r);
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         src_shadow = '0;
         dst_shadow = '0;
         dma_running = 1'b0;
         hblank_xfer = 1'b0;
         blocks_remaining = BLOCKS_IDLE;
         block_bytes_remaining = 5'(BLOCK_BYTES);
         in_hblank_prev = 1'b0;
         responses_due.delete();
      end else if (req_valid && req_ready) begin
         compute_dma_responses(req_data);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (responses_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: rd=%h act=%b copy=%b src=%h vram=%h last=%b",
                        rsp_data.read_data, rsp_data.transfer_active, rsp_data.copy_valid,
                        rsp_data.src_addr, rsp_data.vram_addr, rsp_data.last);
         end else begin
            want = responses_due.pop_front();
            if (rsp_data.read_data !== want.read_data
                || rsp_data.transfer_active !== want.transfer_active
                || rsp_data.copy_valid !== want.copy_valid
                || rsp_data.src_addr !== want.src_addr
                || rsp_data.vram_addr !== want.vram_addr
                || rsp_data.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $write("mismatch at %0t: rd=%h/%h act=%b/%b copy=%b/%b ", $realtime,
                         rsp_data.read_data, want.read_data,
                         rsp_data.transfer_active, want.transfer_active,
                         rsp_data.copy_valid, want.copy_valid);
                  $display("src=%h/%h vram=%h/%h last=%b/%b (got/expected)",
                           rsp_data.src_addr, want.src_addr,
                           rsp_data.vram_addr, want.vram_addr,
                           rsp_data.last, want.last);
               end
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_count = hold_len;
         hold_len = 0;
      end
      if (hold_count > 0) begin
         rsp_ready = 1'b0;
         hold_count--;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input op_type op, input logic [2:0] sel,
                               input logic [7:0] value, input logic [1:0] mode);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data = '{op: op, reg_sel: sel, write_data: value, video_mode: mode};
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic test_register_access();
      send_request(OP_READ, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_WRITE, SEL_SRC_HI, 8'hFF, 2'd0);
      send_request(OP_WRITE, SEL_SRC_LO, 8'hFF, 2'd3);
      send_request(OP_WRITE, SEL_DST_HI, 8'hFF, 2'd0);
      send_request(OP_WRITE, SEL_DST_LO, 8'hFF, 2'd3);
      for (int s = 0; s < 4; s++)
         send_request(OP_READ, 3'(s), 8'h00, 2'd1);
      send_request(OP_READ, 3'd7, 8'h00, 2'd2);
      // unused selector: write must leave everything alone
      send_request(OP_WRITE, 3'd5, 8'hAA, 2'd0);
   endtask

   task automatic test_directed_transfers();
      send_request(OP_TICK, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_QUERY, SEL_CTRL, 8'h00, MODE_HBLANK);
      // one general block, wraps the address around the top of memory
      send_request(OP_WRITE, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_QUERY, SEL_CTRL, 8'h00, 2'd2);
      for (int i = 0; i < BLOCK_BYTES / BYTES_PER_TICK; i++)
         send_request(OP_TICK, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_READ, SEL_CTRL, 8'h00, 2'd0);
      // h-blank transfer with the largest count, stopped part way
      send_request(OP_WRITE, SEL_CTRL, 8'hFF, 2'd0);
      send_request(OP_QUERY, SEL_CTRL, 8'h00, 2'd1);
      send_request(OP_QUERY, SEL_CTRL, 8'h00, MODE_HBLANK);
      send_request(OP_TICK, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_QUERY, SEL_CTRL, 8'h00, 2'd3);
      send_request(OP_WRITE, SEL_CTRL, 8'h80, 2'd0);
      send_request(OP_WRITE, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_READ, SEL_CTRL, 8'h00, 2'd0);
   endtask

   task automatic test_backpressure();
      send_request(OP_WRITE, SEL_CTRL, 8'h03, 2'd0);
      @(posedge clock);
      hold_len = 300;
      @(negedge clock);
      for (int i = 0; i < 30; i++)
         send_request(OP_TICK, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_READ, SEL_CTRL, 8'h00, 2'd0);
      send_request(OP_WRITE, SEL_CTRL, 8'h00, 2'd0);
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      int         sent;
      int         steps;
      int         kind;
      logic [2:0] sel;
      logic [7:0] ctrl;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            for (int s = 0; s < 4; s++) begin
               if ($urandom_range(0, 3) != 0) begin
                  send_request(OP_WRITE, 3'(s), 8'($urandom), 2'($urandom));
                  sent++;
               end
            end
            ctrl[7] = 1'($urandom_range(0, 1));
            ctrl[6:0] = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) :
                        7'($urandom_range(0, 2));
            send_request(OP_WRITE, SEL_CTRL, ctrl, 2'($urandom));
            sent++;
            steps = 0;
            while (dma_running && steps < 60) begin
               kind = $urandom_range(0, 39);
               if (kind < 20)
                  send_request(OP_TICK, 3'($urandom), 8'($urandom), 2'($urandom));
               else if (kind < 32)
                  send_request(OP_QUERY, 3'($urandom), 8'($urandom),
                               $urandom_range(0, 1) ? MODE_HBLANK : 2'($urandom_range(1, 3)));
               else if (kind < 36)
                  send_request(OP_READ, 3'($urandom_range(0, 4)), 8'($urandom),
                               2'($urandom));
               else if (kind < 38)
                  send_request(OP_WRITE, SEL_CTRL, 8'($urandom) | 8'h80, 2'($urandom));
               else if (kind < 39)
                  send_request(OP_WRITE, 3'($urandom_range(0, 3)), 8'($urandom),
                               2'($urandom));
               else
                  send_request(OP_WRITE, SEL_CTRL, 8'($urandom) & 8'h7F, 2'($urandom));
               sent++;
               steps++;
            end
            // long transfers are cut short so the run stays bounded
            if (dma_running) begin
               send_request(OP_WRITE, SEL_CTRL, 8'($urandom) & 8'h7F, 2'($urandom));
               sent++;
            end
         end else begin
            sel = 3'($urandom);
            kind = $urandom_range(0, 3);
            send_request(op_type'(kind), sel, 8'($urandom), 2'($urandom));
            if (kind != OP_WRITE || sel <= SEL_CTRL)
               sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_access();
      test_directed_transfers();
      test_backpressure();
      test_random_traffic(250, 0, 0);
      test_random_traffic(250, 49, 0);
      test_random_traffic(250, 0, 49);
      test_random_traffic(250, 28, 28);

      req_valid = 1'b0;
      rsp_stall_pct = 0;
      while (responses_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && responses_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> vram_dma_controller.f
rtl/vdma_pkg.sv
rtl/vdma_regs.sv
rtl/vram_dma_controller.sv
sim/vram_dma_controller_test.sv
